FILE: src/cpe_pkg.sv
// Package: shared constants, register indexes and blade sign function.
`timescale 1ns / 1ps
`default_nettype none
package cpe_pkg;
	localparam int MAX_N = 4;
	localparam int DEPTH = 1 << MAX_N;
	localparam int AW    = MAX_N;

	localparam logic [1:0] REG_SIG_POS  = 2'd0;
	localparam logic [1:0] REG_SIG_NEG  = 2'd1;
	localparam logic [1:0] REG_SIG_NULL = 2'd2;
	localparam logic [1:0] REG_KIND     = 2'd3;

	localparam logic [1:0] KIND_GEO   = 2'd0;
	localparam logic [1:0] KIND_OUTER = 2'd1;
	localparam logic [1:0] KIND_LCON  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;  // no pair contributes

	typedef struct packed {
		logic zero;
		logic neg;
	} sign_t;

	// sign of e_a * e_b: reorder parity plus squares of shared vectors
	function automatic sign_t blade_sign(input logic [AW-1:0] a, input logic [AW-1:0] b,
			input logic [3:0] p, input logic [3:0] pq);
		sign_t s;
		logic [AW-1:0] acc;
		logic [AW-1:0] hi;
		s.zero = 1'b0;
		s.neg  = 1'b0;
		acc    = a;
		for (int k = 0; k < MAX_N; k++) begin
			if (b[k] && !s.zero) begin
				hi = acc >> (k + 1);
				s.neg = s.neg ^ (^hi);
				if (acc[k]) begin
					if (4'(k) >= pq) s.zero = 1'b1;
					else if (4'(k) >= p) s.neg = ~s.neg;
					acc[k] = 1'b0;
				end else begin
					acc[k] = 1'b1;
				end
			end
		end
		return s;
	endfunction
endpackage
`default_nettype wire

FILE: src/cpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module cpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/clifford_product_engine_core.sv
// Top level: Clifford algebra product engine over bitmap-addressed blades.
//
// Usage:
//  - s_axis: one beat loads a coefficient pair (a into the left store, b into
//    the right store) at blade tdata[3:0]. tlast on a beat starts the product.
//  - cfg: writes sig_pos, sig_neg, sig_null, product_kind by index; always
//    ready; the user must only write it while the engine is idle (not enforced).
//  - m_axis: one beat per result blade, ascending; tlast on the final one,
//    tuser flags a bad signature (p+q+r > MAX_N; all coefficients zero).
// Timing: a product with n = p+q+r runs each output blade k as a pass over i
//  (j = i ^ k) through the two store RAMs, one pair per cycle, then drains the
//  pipeline and emits the blade. The single read port of each store RAM sets
//  the pair rate.
// Reset: signature resets to Cl(3,0,0), geometric product; store valid bits
//  clear so every blade reads as zero. After a run the valid bits clear again.
// Stall: a held m_axis beat stalls the engine in its emit step; after the final
//  beat is loaded into the output register the engine takes new beats at once.
`timescale 1ns / 1ps
`default_nettype none
module clifford_product_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // blade_in[3:0], a_coef[35:4], b_coef[67:36], pad
	input  wire logic        s_axis_tlast,  // last_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,  // blade_out[3:0], result_coef[35:4], pad
	output logic             m_axis_tlast,  // last_out
	output logic             m_axis_tuser,  // bad_signature
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam int AW = cpe_pkg::AW;

	logic [1:0] state_q;
	logic [2:0] sig_pos_q, sig_neg_q, sig_null_q;
	logic [1:0] kind_q;
	logic [cpe_pkg::DEPTH-1:0] vld_q;     // blade holds a loaded pair
	logic [AW-1:0] k_q, i_q, last_idx_q;
	logic bad_q;
	logic signed [63:0] acc_q;

	// pipeline
	logic v_s1, v_s2, v_s3;
	logic [AW-1:0] i_s1, j_s1;
	logic signed [31:0] a_s2, b_s2;
	logic en_s2, neg_s2, en_s3, neg_s3;
	logic signed [63:0] prod_s3;

	logic [31:0] left_rd, right_rd;
	logic load;
	logic [AW-1:0] blade_in;
	logic [4:0] n_sum;
	logic [3:0] pq_sum;
	cpe_pkg::sign_t sgn;
	logic keep;
	logic signed [63:0] rnd;
	logic [31:0] sat;
	logic out_free;

	logic [31:0] out_coef_q;
	logic [AW-1:0] out_blade_q;
	logic out_last_q, out_bad_q, out_vld_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign load          = s_axis_tvalid && s_axis_tready;
	assign blade_in      = s_axis_tdata[AW-1:0];
	assign n_sum         = 5'(sig_pos_q) + 5'(sig_neg_q) + 5'(sig_null_q);
	assign pq_sum        = 4'(sig_pos_q) + 4'(sig_neg_q);

	cpe_ram #(.WIDTH(32), .DEPTH(cpe_pkg::DEPTH)) u_left (
		.clk(clk), .we(load), .waddr(blade_in), .wdata(s_axis_tdata[35:4]),
		.raddr(i_q), .rdata(left_rd)
	);
	cpe_ram #(.WIDTH(32), .DEPTH(cpe_pkg::DEPTH)) u_right (
		.clk(clk), .we(load), .waddr(blade_in), .wdata(s_axis_tdata[67:36]),
		.raddr(i_q ^ k_q), .rdata(right_rd)
	);

	// contribution filter and sign of the pair in stage 1
	always_comb begin
		sgn = cpe_pkg::blade_sign(i_s1, j_s1, {1'b0, sig_pos_q}, pq_sum);
		case (kind_q)
			cpe_pkg::KIND_GEO:   keep = 1'b1;
			cpe_pkg::KIND_OUTER: keep = ((i_s1 & j_s1) == '0);
			cpe_pkg::KIND_LCON:  keep = ((i_s1 & j_s1) == i_s1);
			default:             keep = 1'b0;
		endcase
		keep = keep && !sgn.zero && vld_q[i_s1] && vld_q[j_s1];
	end

	// round half up to Q16.16: floor((p + 2^15) / 2^16)
	assign rnd = (prod_s3 + 64'sd32768) >>> 16;

	always_comb begin
		if (acc_q > 64'sd2147483647) sat = 32'h7fff_ffff;
		else if (acc_q < -64'sd2147483648) sat = 32'h8000_0000;
		else sat = acc_q[31:0];
	end

	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk) begin
		a_s2    <= left_rd;
		b_s2    <= right_rd;
		neg_s2  <= sgn.neg;
		en_s2   <= keep;
		prod_s3 <= a_s2 * b_s2;
		neg_s3  <= neg_s2;
		en_s3   <= en_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sig_pos_q  <= 3'd3;
			sig_neg_q  <= 3'd0;
			sig_null_q <= 3'd0;
			kind_q     <= cpe_pkg::KIND_GEO;
			vld_q      <= '0;
			k_q        <= '0;
			i_q        <= '0;
			last_idx_q <= '0;
			bad_q      <= 1'b0;
			acc_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			i_s1       <= '0;
			j_s1       <= '0;
			out_vld_q  <= 1'b0;
			out_coef_q <= '0;
			out_blade_q <= '0;
			out_last_q <= 1'b0;
			out_bad_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					cpe_pkg::REG_SIG_POS:  sig_pos_q  <= cfg_data[2:0];
					cpe_pkg::REG_SIG_NEG:  sig_neg_q  <= cfg_data[2:0];
					cpe_pkg::REG_SIG_NULL: sig_null_q <= cfg_data[2:0];
					cpe_pkg::REG_KIND:     kind_q     <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (m_axis_tready) out_vld_q <= 1'b0;

			v_s1 <= (state_q == ST_RUN);
			i_s1 <= i_q;
			j_s1 <= i_q ^ k_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && en_s3) acc_q <= neg_s3 ? acc_q - rnd : acc_q + rnd;

			case (state_q)
				ST_IDLE: begin
					if (load) begin
						vld_q[blade_in] <= 1'b1;
						if (s_axis_tlast) begin
							k_q   <= '0;
							i_q   <= '0;
							acc_q <= '0;
							bad_q <= (n_sum > 5'(cpe_pkg::MAX_N));
							if (n_sum > 5'(cpe_pkg::MAX_N)) begin
								last_idx_q <= AW'(cpe_pkg::DEPTH - 1);
								state_q    <= ST_EMIT;
							end else begin
								last_idx_q <= AW'((5'd1 << n_sum) - 5'd1);
								state_q    <= ST_RUN;
							end
						end
					end
				end
				ST_RUN: begin
					if (i_q == last_idx_q) state_q <= ST_DRAIN;
					else i_q <= i_q + 1'b1;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_vld_q   <= 1'b1;
						out_blade_q <= k_q;
						out_coef_q  <= bad_q ? 32'd0 : sat;
						out_last_q  <= (k_q == last_idx_q);
						out_bad_q   <= bad_q;
						acc_q       <= '0;
						i_q         <= '0;
						if (k_q == last_idx_q) begin
							vld_q   <= '0;  // stores read as zero for the next run
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= bad_q ? ST_EMIT : ST_RUN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {4'd0, out_coef_q, out_blade_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_bad_q;
endmodule
`default_nettype wire
